// File: src/uecr_pkg.sv
// Package for the ultrasonic echo ranger: register indexes, reset values,
// distance codes and clock limits. Used by ultrasonic_echo_ranger_with_clock_top.
package uecr_pkg;

  localparam int DIST_W = 16;
  localparam int IVL_W  = 20;
  localparam int DIV_W  = 8;
  localparam int IPS_W  = 4;
  localparam int CFG_W  = 20;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_INTERVAL_TICKS = 2'd0;
  localparam logic [IDX_W-1:0] REG_ECHO_DIVISOR   = 2'd1;
  localparam logic [IDX_W-1:0] REG_INTERVALS_PS   = 2'd2;

  localparam logic [IVL_W-1:0] INTERVAL_RESET = 20'd100000;
  localparam logic [DIV_W-1:0] DIVISOR_RESET  = 8'd58;
  localparam logic [IPS_W-1:0] IPS_RESET      = 4'd10;

  localparam logic [DIST_W-1:0] NO_ECHO  = 16'hFFFF;
  localparam logic [DIST_W-1:0] MAX_DIST = 16'hFFFE;

  localparam logic [5:0] SEC_LIMIT  = 6'd60;
  localparam logic [5:0] MIN_LIMIT  = 6'd60;
  localparam logic [4:0] HOUR_LIMIT = 5'd24;

endpackage

// File: src/ultrasonic_echo_ranger_with_clock_top.sv
// Echo ranger top level: tick handling, bit-serial divider, 24-hour clock.
// Depends on uecr_pkg.
//
// Usage: each request on the input channel (in_valid/in_ready, echo_level)
// is one microsecond tick with the sampled echo level. Every tick gives
// exactly one result on the output channel (out_valid/out_ready): the
// latest distance, a done flag for a falling edge that closed a
// measurement, the interval trigger strobe, and the clock time.
// Configuration registers are written through cfg_we/cfg_index/cfg_data:
// index 0 interval ticks, 1 echo divisor, 2 intervals per second. The
// user must write them only while the block is idle; it is not enforced.
// Flow: a tick without a measurement goes from S_IDLE to S_PUSH, which
// loads the output register. A tick whose falling edge closes a pulse
// with no counter wrap first runs the restoring divider in S_DIV, one
// quotient bit per cycle, and then goes on to S_PUSH.
// One tick is in work at a time; the next is taken once the result has
// moved to the output register, even while that register waits.
// Reset: synchronous, clears all counters and the clock and restores the
// register defaults. A stalled receiver holds the output register and,
// once the next result is ready, the block waits for it too.
module ultrasonic_echo_ranger_with_clock_top #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [uecr_pkg::IDX_W-1:0]  cfg_index,
  input  logic [uecr_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        echo_level,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [uecr_pkg::DIST_W-1:0] distance,
  output logic                        measurement_done,
  output logic                        trigger_pulse,
  output logic [4:0]                  clock_hours,
  output logic [5:0]                  clock_minutes,
  output logic [5:0]                  clock_seconds
);

  localparam int CNT_W = $clog2(COUNT_WIDTH + 1);
  localparam int QW    = (COUNT_WIDTH > uecr_pkg::DIST_W) ? COUNT_WIDTH : uecr_pkg::DIST_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;

  logic [1:0] state;

  // configuration
  logic [uecr_pkg::IVL_W-1:0] interval_ticks;
  logic [uecr_pkg::DIV_W-1:0] echo_divisor;
  logic [uecr_pkg::IPS_W-1:0] intervals_per_second;

  // ranging and clock state
  logic [uecr_pkg::IVL_W-1:0]  interval_count;
  logic [COUNT_WIDTH-1:0]      time_count;
  logic                        wrap_flag;
  logic                        awaiting_fall;
  logic [COUNT_WIDTH-1:0]      start_capture;
  logic                        previous_echo;
  logic [uecr_pkg::DIST_W-1:0] last_distance;
  logic [uecr_pkg::IPS_W-1:0]  tenths_count;
  logic [5:0]                  seconds_count;
  logic [5:0]                  minutes_count;
  logic [4:0]                  hours_count;

  logic pend_done;
  logic pend_trig;

  // divider
  logic [COUNT_WIDTH-1:0]      div_q;
  logic [uecr_pkg::DIV_W-1:0]  div_rem;
  logic [uecr_pkg::DIV_W-1:0]  div_den;
  logic [CNT_W-1:0]            div_count;
  logic [uecr_pkg::DIV_W:0]    rem_sh;
  logic                        q_bit;
  logic [uecr_pkg::DIV_W:0]    rem_diff;
  logic [COUNT_WIDTH-1:0]      q_fin;
  logic [QW-1:0]               q_ext;
  logic [uecr_pkg::DIST_W-1:0] q_sat;

  // tick step
  logic                        rising;
  logic                        falling;
  logic                        start_pulse;
  logic                        end_pulse;
  logic                        wrap_flag_next;
  logic [COUNT_WIDTH-1:0]      tc_inc;
  logic [COUNT_WIDTH-1:0]      time_count_next;
  logic [COUNT_WIDTH-1:0]      span;
  logic [uecr_pkg::IVL_W-1:0]  ic_inc;
  logic                        interval_end;
  logic [uecr_pkg::IPS_W-1:0]  tenths_inc;
  logic                        sec_step;
  logic                        min_step;
  logic                        hour_step;
  logic [5:0]                  sec_inc;
  logic [5:0]                  min_inc;
  logic [4:0]                  hour_inc;
  logic                        accept;
  logic                        push;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign push     = !out_valid || out_ready;

  always_comb begin
    rising      = echo_level && !previous_echo;
    falling     = !echo_level && previous_echo;
    start_pulse = !awaiting_fall && rising;
    end_pulse   = awaiting_fall && falling;
    span        = time_count - start_capture;

    wrap_flag_next = start_pulse ? 1'b0 : wrap_flag;
    tc_inc         = time_count + COUNT_WIDTH'(1);
    if (tc_inc == '0) begin
      wrap_flag_next = 1'b1;
    end

    ic_inc          = interval_count + uecr_pkg::IVL_W'(1);
    interval_end    = (ic_inc >= interval_ticks);
    time_count_next = interval_end ? '0 : tc_inc;

    tenths_inc = tenths_count + uecr_pkg::IPS_W'(1);
    sec_inc    = seconds_count + 6'd1;
    min_inc    = minutes_count + 6'd1;
    hour_inc   = hours_count + 5'd1;
    sec_step   = interval_end && (tenths_inc >= intervals_per_second);
    min_step   = sec_step && (sec_inc >= uecr_pkg::SEC_LIMIT);
    hour_step  = min_step && (min_inc >= uecr_pkg::MIN_LIMIT);
  end

  // one restoring step per cycle
  always_comb begin
    rem_sh   = {div_rem, div_q[COUNT_WIDTH-1]};
    rem_diff = rem_sh - {1'b0, div_den};
    q_bit    = (rem_sh >= {1'b0, div_den});
    q_fin    = {div_q[COUNT_WIDTH-2:0], q_bit};
    q_ext    = QW'(q_fin);
    if (div_den == '0 || q_ext > QW'(uecr_pkg::MAX_DIST)) begin
      q_sat = uecr_pkg::MAX_DIST;
    end else begin
      q_sat = q_ext[uecr_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      out_valid            <= 1'b0;
      interval_ticks       <= uecr_pkg::INTERVAL_RESET;
      echo_divisor         <= uecr_pkg::DIVISOR_RESET;
      intervals_per_second <= uecr_pkg::IPS_RESET;
      interval_count       <= '0;
      time_count           <= '0;
      wrap_flag            <= 1'b0;
      awaiting_fall        <= 1'b0;
      start_capture        <= '0;
      previous_echo        <= 1'b0;
      last_distance        <= '0;
      tenths_count         <= '0;
      seconds_count        <= '0;
      minutes_count        <= '0;
      hours_count          <= '0;
      pend_done            <= 1'b0;
      pend_trig            <= 1'b0;
      div_count            <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          uecr_pkg::REG_INTERVAL_TICKS: interval_ticks <= cfg_data;
          uecr_pkg::REG_ECHO_DIVISOR:
            echo_divisor <= cfg_data[uecr_pkg::DIV_W-1:0];
          uecr_pkg::REG_INTERVALS_PS:
            intervals_per_second <= cfg_data[uecr_pkg::IPS_W-1:0];
          default: ;
        endcase
      end

      // a push in the same cycle reloads the register instead
      if (out_valid && out_ready && state != S_PUSH) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            previous_echo <= echo_level;
            if (start_pulse) begin
              start_capture <= time_count;
              awaiting_fall <= 1'b1;
            end
            if (end_pulse) begin
              awaiting_fall <= 1'b0;
              if (wrap_flag) begin
                last_distance <= uecr_pkg::NO_ECHO;
              end
            end
            wrap_flag      <= wrap_flag_next;
            time_count     <= time_count_next;
            interval_count <= interval_end ? '0 : ic_inc;
            if (interval_end) begin
              tenths_count <= sec_step ? '0 : tenths_inc;
            end
            if (sec_step) begin
              seconds_count <= min_step ? '0 : sec_inc;
            end
            if (min_step) begin
              minutes_count <= hour_step ? '0 : min_inc;
            end
            if (hour_step) begin
              hours_count <= (hour_inc >= uecr_pkg::HOUR_LIMIT) ? '0 : hour_inc;
            end
            pend_done <= end_pulse;
            pend_trig <= interval_end;
            // start the divider on a clean pulse end
            div_q     <= span;
            div_rem   <= '0;
            div_den   <= echo_divisor;
            div_count <= CNT_W'(COUNT_WIDTH);
            state     <= (end_pulse && !wrap_flag) ? S_DIV : S_PUSH;
          end
        end
        S_DIV: begin
          div_q     <= q_fin;
          div_rem   <= q_bit ? rem_diff[uecr_pkg::DIV_W-1:0]
                             : rem_sh[uecr_pkg::DIV_W-1:0];
          div_count <= div_count - CNT_W'(1);
          if (div_count == CNT_W'(1)) begin
            last_distance <= q_sat;
            state         <= S_PUSH;
          end
        end
        S_PUSH: begin
          // hold the result until the output register frees up
          if (push) begin
            out_valid        <= 1'b1;
            distance         <= last_distance;
            measurement_done <= pend_done;
            trigger_pulse    <= pend_trig;
            clock_hours      <= hours_count;
            clock_minutes    <= minutes_count;
            clock_seconds    <= seconds_count;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_den != '0) |-> (div_rem < div_den))
    else $error("divider remainder not below divisor");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("request accepted while previous tick still in work");

  a_div_count_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_count != '0 && div_count <= CNT_W'(COUNT_WIDTH)))
    else $error("divider step count out of range");

  a_clock_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (clock_seconds < uecr_pkg::SEC_LIMIT &&
                   clock_minutes < uecr_pkg::MIN_LIMIT &&
                   clock_hours < uecr_pkg::HOUR_LIMIT))
    else $error("clock field out of range");

  a_div_from_fall: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (pend_done && !awaiting_fall))
    else $error("divider running without a closed pulse");

endmodule

// File: tb/sv/echo_ranger_checker.sv
// Checker for the echo ranger: watches config writes, the input and output
// channels, predicts every tick result and compares it field by field.
// Depends on uecr_pkg.
`timescale 1ns / 100ps

module echo_ranger_checker #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [uecr_pkg::IDX_W-1:0]  cfg_index,
  input  logic [uecr_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        echo_level,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [uecr_pkg::DIST_W-1:0] distance,
  input  logic                        measurement_done,
  input  logic                        trigger_pulse,
  input  logic [4:0]                  clock_hours,
  input  logic [5:0]                  clock_minutes,
  input  logic [5:0]                  clock_seconds,
  output int                          fail_count,
  output int                          pending,
  output int                          ticks_checked,
  output int                          measurements,
  output int                          no_echo_seen,
  output int                          saturated_seen,
  output int                          strobes
);

  typedef struct packed {
    logic [uecr_pkg::DIST_W-1:0] distance;
    logic                        done;
    logic                        trig;
    logic [4:0]                  hours;
    logic [5:0]                  minutes;
    logic [5:0]                  seconds;
  } tick_result_t;

  tick_result_t expected_ticks[$];

  // register copies
  logic [uecr_pkg::IVL_W-1:0] ivl_ticks;
  logic [uecr_pkg::DIV_W-1:0] divisor;
  logic [uecr_pkg::IPS_W-1:0] ips;

  // ranger and clock state
  logic [uecr_pkg::IVL_W-1:0]  ivl_cnt;
  logic [COUNT_WIDTH-1:0]      time_cnt;
  logic [COUNT_WIDTH-1:0]      start_cap;
  logic                        wrapped;
  logic                        in_pulse;
  logic                        prev_echo;
  logic [uecr_pkg::DIST_W-1:0] last_dist;
  logic [3:0]                  tenths;
  logic [5:0]                  sec_cnt;
  logic [5:0]                  min_cnt;
  logic [4:0]                  hr_cnt;

  function automatic void reset_ranger();
    ivl_ticks = uecr_pkg::INTERVAL_RESET;
    divisor   = uecr_pkg::DIVISOR_RESET;
    ips       = uecr_pkg::IPS_RESET;
    ivl_cnt   = '0;
    time_cnt  = '0;
    start_cap = '0;
    wrapped   = 1'b0;
    in_pulse  = 1'b0;
    prev_echo = 1'b0;
    last_dist = '0;
    tenths    = '0;
    sec_cnt   = '0;
    min_cnt   = '0;
    hr_cnt    = '0;
  endfunction

  function automatic void advance_clock();
    tenths = tenths + 1'b1;
    if (tenths < ips) return;
    tenths = '0;
    sec_cnt = sec_cnt + 1'b1;
    if (sec_cnt < uecr_pkg::SEC_LIMIT) return;
    sec_cnt = '0;
    min_cnt = min_cnt + 1'b1;
    if (min_cnt < uecr_pkg::MIN_LIMIT) return;
    min_cnt = '0;
    hr_cnt = hr_cnt + 1'b1;
    if (hr_cnt >= uecr_pkg::HOUR_LIMIT) hr_cnt = '0;
  endfunction

  function automatic tick_result_t predict_tick(input logic echo);
    tick_result_t           r;
    logic                   rising;
    logic                   falling;
    logic [COUNT_WIDTH-1:0] span;
    longint unsigned        quo;
    r = '0;
    rising  = echo && !prev_echo;
    falling = !echo && prev_echo;
    prev_echo = echo;
    // edges use the count before this tick's advance
    if (!in_pulse) begin
      if (rising) begin
        start_cap = time_cnt;
        wrapped   = 1'b0;
        in_pulse  = 1'b1;
      end
    end else if (falling) begin
      if (wrapped) begin
        last_dist = uecr_pkg::NO_ECHO;
      end else begin
        span = time_cnt - start_cap;
        quo  = uecr_pkg::MAX_DIST;
        if (divisor != '0) quo = span / divisor;
        if (quo > uecr_pkg::MAX_DIST) quo = uecr_pkg::MAX_DIST;
        last_dist = quo[uecr_pkg::DIST_W-1:0];
      end
      in_pulse = 1'b0;
      r.done   = 1'b1;
    end
    time_cnt = time_cnt + 1'b1;
    if (time_cnt == '0) wrapped = 1'b1;
    // interval end clears the counter but leaves a fresh wrap flag set
    ivl_cnt = ivl_cnt + 1'b1;
    if (ivl_cnt >= ivl_ticks) begin
      ivl_cnt  = '0;
      time_cnt = '0;
      r.trig   = 1'b1;
      advance_clock();
    end
    r.distance = last_dist;
    r.hours    = hr_cnt;
    r.minutes  = min_cnt;
    r.seconds  = sec_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    tick_result_t exp_r;
    tick_result_t got_r;
    logic         bad;
    if (rst) begin
      reset_ranger();
      expected_ticks.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          uecr_pkg::REG_INTERVAL_TICKS: ivl_ticks = cfg_data[uecr_pkg::IVL_W-1:0];
          uecr_pkg::REG_ECHO_DIVISOR:   divisor   = cfg_data[uecr_pkg::DIV_W-1:0];
          uecr_pkg::REG_INTERVALS_PS:   ips       = cfg_data[uecr_pkg::IPS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got_r.distance = distance;
        got_r.done     = measurement_done;
        got_r.trig     = trigger_pulse;
        got_r.hours    = clock_hours;
        got_r.minutes  = clock_minutes;
        got_r.seconds  = clock_seconds;
        if (expected_ticks.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: dist %0d done %0b trig %0b %0d:%0d:%0d",
                     got_r.distance, got_r.done, got_r.trig,
                     got_r.hours, got_r.minutes, got_r.seconds);
        end else begin
          exp_r = expected_ticks.pop_front();
          bad = (got_r.distance !== exp_r.distance) || (got_r.done !== exp_r.done) ||
                (got_r.trig !== exp_r.trig) || (got_r.hours !== exp_r.hours) ||
                (got_r.minutes !== exp_r.minutes) || (got_r.seconds !== exp_r.seconds);
          if (bad) begin
            fail_count++;
            if (fail_count <= 10) begin
              $write("tick %0d: expected dist %0d done %0b trig %0b %0d:%0d:%0d,",
                     ticks_checked, exp_r.distance, exp_r.done, exp_r.trig,
                     exp_r.hours, exp_r.minutes, exp_r.seconds);
              $display(" got dist %0d done %0b trig %0b %0d:%0d:%0d",
                       got_r.distance, got_r.done, got_r.trig,
                       got_r.hours, got_r.minutes, got_r.seconds);
            end
          end
          ticks_checked++;
          if (exp_r.done) begin
            measurements++;
            if (exp_r.distance == uecr_pkg::NO_ECHO) no_echo_seen++;
            if (exp_r.distance == uecr_pkg::MAX_DIST) saturated_seen++;
          end
          if (exp_r.trig) strobes++;
        end
      end
      if (in_valid && in_ready) expected_ticks.push_back(predict_tick(echo_level));
    end
    pending = expected_ticks.size();
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top for ultrasonic_echo_ranger_with_clock_top: clock, reset,
// tick stimulus, receiver stalls and verdict. Depends on uecr_pkg and
// echo_ranger_checker.
`timescale 1ns / 100ps

module tb_top;

  localparam int COUNT_W    = 16;
  localparam int CYCLE_CAP  = 4000000;
  localparam int HOLD_CYCLES = 400;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [uecr_pkg::IDX_W-1:0]  cfg_index;
  logic [uecr_pkg::CFG_W-1:0]  cfg_data;
  logic                        in_valid;
  logic                        in_ready;
  logic                        echo_level;
  logic                        out_valid;
  logic                        out_ready;
  logic [uecr_pkg::DIST_W-1:0] distance;
  logic                        measurement_done;
  logic                        trigger_pulse;
  logic [4:0]                  clock_hours;
  logic [5:0]                  clock_minutes;
  logic [5:0]                  clock_seconds;

  int fail_count;
  int pending;
  int ticks_checked;
  int measurements;
  int no_echo_seen;
  int saturated_seen;
  int strobes;

  int   sender_idle_pct;
  int   recv_stall_pct;
  logic hold_off;
  int   cycles;

  ultrasonic_echo_ranger_with_clock_top #(.COUNT_WIDTH(COUNT_W)) u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .echo_level(echo_level),
    .out_valid(out_valid), .out_ready(out_ready),
    .distance(distance), .measurement_done(measurement_done),
    .trigger_pulse(trigger_pulse), .clock_hours(clock_hours),
    .clock_minutes(clock_minutes), .clock_seconds(clock_seconds)
  );

  echo_ranger_checker #(.COUNT_WIDTH(COUNT_W)) u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .echo_level(echo_level),
    .out_valid(out_valid), .out_ready(out_ready),
    .distance(distance), .measurement_done(measurement_done),
    .trigger_pulse(trigger_pulse), .clock_hours(clock_hours),
    .clock_minutes(clock_minutes), .clock_seconds(clock_seconds),
    .fail_count(fail_count), .pending(pending), .ticks_checked(ticks_checked),
    .measurements(measurements), .no_echo_seen(no_echo_seen),
    .saturated_seen(saturated_seen), .strobes(strobes)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random stalls, or a hard hold-off while pressure is on
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_CAP) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_tick(input logic lvl);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    echo_level <= lvl;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_run(input logic lvl, input int n);
    int k;
    for (k = 0; k < n; k++) send_tick(lvl);
  endtask

  // drop the request and wait until every tick result is back
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic cfg_write(input logic [uecr_pkg::IDX_W-1:0] idx,
                           input logic [uecr_pkg::CFG_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_ranger(input logic [uecr_pkg::IVL_W-1:0] ivl,
                            input logic [uecr_pkg::DIV_W-1:0] dv,
                            input logic [uecr_pkg::IPS_W-1:0] per_sec);
    cfg_write(uecr_pkg::REG_INTERVAL_TICKS, uecr_pkg::CFG_W'(ivl));
    cfg_write(uecr_pkg::REG_ECHO_DIVISOR, uecr_pkg::CFG_W'(dv));
    cfg_write(uecr_pkg::REG_INTERVALS_PS, uecr_pkg::CFG_W'(per_sec));
  endtask

  task automatic random_ranger();
    logic [uecr_pkg::IVL_W-1:0] ivl;
    logic [uecr_pkg::DIV_W-1:0] dv;
    case ($urandom_range(9))
      0:       ivl = '0;
      1:       ivl = '1;
      2:       ivl = 20'd1;
      default: ivl = uecr_pkg::IVL_W'($urandom_range(2, 300));
    endcase
    case ($urandom_range(5))
      0:       dv = 8'd1;
      1:       dv = '1;
      default: dv = uecr_pkg::DIV_W'($urandom_range(0, 255));
    endcase
    set_ranger(ivl, dv, uecr_pkg::IPS_W'($urandom_range(0, 15)));
  endtask

  // mostly clean pulses with random gaps and widths, some single noisy ticks
  task automatic random_echoes(input int count);
    int n;
    int gap;
    int width;
    n = 0;
    while (n < count) begin
      if ($urandom_range(9) == 0) begin
        send_tick(1'($urandom_range(1)));
        n++;
      end else begin
        gap   = $urandom_range(1, 6);
        width = $urandom_range(1, 30);
        send_run(1'b0, gap);
        send_run(1'b1, width);
        n += gap + width;
      end
    end
  endtask

  initial begin
    int mode;
    int part;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    echo_level      = 1'b0;
    hold_off        = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: short pulses and short low runs
    send_tick(1'b0);
    send_run(1'b1, 3);
    send_run(1'b0, 2);
    send_tick(1'b1);
    send_tick(1'b0);
    settle();

    // zero interval, zero divisor, zero prescale
    set_ranger('0, '0, '0);
    send_run(1'b1, 2);
    send_run(1'b0, 2);
    settle();

    // interval of one leaves the time counter at zero and no pulse open
    set_ranger(20'd1, '1, '1);
    send_tick(1'b1);
    send_run(1'b0, 2);
    send_tick(1'b1);
    send_tick(1'b0);
    settle();

    // one second per tick: carry the clock past a minute
    set_ranger(20'd1, uecr_pkg::DIVISOR_RESET, 4'd1);
    send_run(1'b0, 64);
    settle();

    for (mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin sender_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      for (part = 0; part < 2; part++) begin
        random_ranger();
        if (mode == 0 && part == 0) begin
          fork
            begin
              repeat (30) @(negedge clk);
              hold_off <= 1'b1;
              repeat (HOLD_CYCLES) @(negedge clk);
              hold_off <= 1'b0;
            end
          join_none
        end
        random_echoes(32);
        settle();
      end
    end

    repeat (2 * COUNT_W + 4) @(negedge clk);
    $display("%0d ticks checked, %0d measurements (%0d no-echo, %0d saturated)",
             ticks_checked, measurements, no_echo_seen, saturated_seen);
    $display("%0d interval strobes over zero, short, long and maximum settings",
             strobes);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
src/uecr_pkg.sv
src/ultrasonic_echo_ranger_with_clock_top.sv
tb/sv/echo_ranger_checker.sv
tb/sv/tb_top.sv
